>>> design/deque_with_indexed_removal_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the deque with indexed removal
// Concurrent assertion shorthands clocked on clk, with and without reset gating.
// ----------------------------------------------------------------------------
`ifndef DEQUE_WITH_INDEXED_REMOVAL_ASSERT_SVH
`define DEQUE_WITH_INDEXED_REMOVAL_ASSERT_SVH

// Checked only while the block is out of reset.
`define DQIR_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, including during reset.
`define DQIR_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/dqir_pkg.sv
// ----------------------------------------------------------------------------
// Deque with indexed removal: shared definitions
// Sizes, opcode and status codes, and the control word sent down the cell row.
// ----------------------------------------------------------------------------
package dqir_pkg;

  localparam int CAPACITY   = 16;
  localparam int WORD_WIDTH = 32;

  localparam int OPCODE_W = 3;
  localparam int IN_W     = 32;
  localparam int POS_W    = 4;
  localparam int OUT_W    = 32;
  localparam int STATUS_W = 2;
  localparam int ENTRY_W  = 5;

  localparam int IDX_W   = $clog2(CAPACITY);
  localparam int COUNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W   = (COUNT_W > POS_W) ? COUNT_W : POS_W;

  typedef enum logic [OPCODE_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_REMOVE_AT  = 3'd4
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_SHIFT_IN,
    CELL_LOAD,
    CELL_REMOVE
  } cell_op_t;

  typedef struct packed {
    cell_op_t         kind;
    logic [IDX_W-1:0] at;
  } cell_ctrl_t;

endpackage

>>> design/dqir_in_if.sv
// ----------------------------------------------------------------------------
// Deque request channel
// Valid/ready channel carrying one operation per beat.
// ----------------------------------------------------------------------------
interface dqir_in_if
  import dqir_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [IN_W-1:0]     push_word;
  logic [POS_W-1:0]    position;

  modport source (output valid, output opcode, output push_word, output position,
                  input ready);
  modport sink (input valid, input opcode, input push_word, input position,
                output ready);
endinterface

>>> design/dqir_out_if.sv
// ----------------------------------------------------------------------------
// Deque result channel
// Valid/ready channel carrying one result per beat.
// ----------------------------------------------------------------------------
interface dqir_out_if
  import dqir_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [OUT_W-1:0]    popped_word;
  logic [STATUS_W-1:0] status;
  logic [ENTRY_W-1:0]  entry_count;

  modport source (output valid, output popped_word, output status, output entry_count,
                  input ready);
  modport sink (input valid, input popped_word, input status, input entry_count,
                output ready);
endinterface

>>> design/dqir_cell.sv
// ----------------------------------------------------------------------------
// Deque storage cell
// Holds one entry and takes a word from its left or right neighbor, or the
// pushed word, as the broadcast control word directs.
// ----------------------------------------------------------------------------
module dqir_cell
  import dqir_pkg::*;
(
  input  logic                  clk,
  input  logic [IDX_W-1:0]      idx,
  input  cell_ctrl_t            ctrl,
  input  logic [WORD_WIDTH-1:0] fill_word,
  input  logic [WORD_WIDTH-1:0] left_word,
  input  logic [WORD_WIDTH-1:0] right_word,
  output logic [WORD_WIDTH-1:0] word
);

  always_ff @(posedge clk) begin
    unique case (ctrl.kind)
      CELL_HOLD: begin
        word <= word;
      end
      CELL_SHIFT_IN: begin
        word <= left_word;
      end
      CELL_LOAD: begin
        if (idx == ctrl.at) begin
          word <= fill_word;
        end
      end
      CELL_REMOVE: begin
        if (idx >= ctrl.at) begin
          word <= right_word;
        end
      end
      default: begin
        word <= word;
      end
    endcase
  end

endmodule

>>> design/dqir_chain.sv
// ----------------------------------------------------------------------------
// Deque cell row
// A row of storage cells, front at cell 0, with a read port for one entry.
// ----------------------------------------------------------------------------
module dqir_chain
  import dqir_pkg::*;
(
  input  logic                  clk,
  input  cell_ctrl_t            ctrl,
  input  logic [WORD_WIDTH-1:0] fill_word,
  input  logic [IDX_W-1:0]      rd_idx,
  output logic [WORD_WIDTH-1:0] rd_word
);

  logic [WORD_WIDTH-1:0] words [CAPACITY];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [WORD_WIDTH-1:0] left_word;
    logic [WORD_WIDTH-1:0] right_word;

    if (i == 0) begin : g_first
      assign left_word = fill_word;
    end else begin : g_inner_left
      assign left_word = words[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_word = '0;
    end else begin : g_inner_right
      assign right_word = words[i+1];
    end

    dqir_cell u_cell (
      .clk        (clk),
      .idx        (IDX_W'(i)),
      .ctrl       (ctrl),
      .fill_word  (fill_word),
      .left_word  (left_word),
      .right_word (right_word),
      .word       (words[i])
    );
  end

  assign rd_word = words[rd_idx];

endmodule

>>> design/deque_with_indexed_removal.sv
// ----------------------------------------------------------------------------
// Deque with indexed removal
// Bounded double-ended queue of words with push and pop at both ends and
// removal at any position counted from the front.
// ----------------------------------------------------------------------------
// The request channel takes one operation per beat: opcode, push_word and
// position. The result channel returns exactly one beat per request with the
// removed word (zero if none), a status code and the entry count afterwards.
// Entries live in a row of cells; every cell updates in the same cycle, so an
// insert at the front or a removal from the middle shifts the whole row at
// once. The result is registered: it appears in the cycle after the request is
// taken, and one request per cycle is sustained while results are taken.
// While a result waits, a new request is taken only in the cycle that the
// waiting result is taken, so a stalled receiver stalls the sender.
// Pops on an empty queue, pushes on a full one and positions at or beyond the
// count report an error status and leave the contents unchanged.
// Reset empties the queue and clears the result valid flag; cell contents are
// not cleared and are never read before they are written.
// ----------------------------------------------------------------------------
module deque_with_indexed_removal
  import dqir_pkg::*;
(
  input logic       clk,
  input logic       rst,
  dqir_in_if.sink   request,
  dqir_out_if.source result
);

  `include "deque_with_indexed_removal_assert.svh"

  logic [COUNT_W-1:0]    count;
  logic [COUNT_W-1:0]    count_next;
  logic                  out_valid;
  logic [OUT_W-1:0]      out_word;
  status_t               out_status;
  logic [ENTRY_W-1:0]    out_count;

  logic                  in_fire;
  status_t               res_status;
  logic                  take;
  cell_ctrl_t            op_ctrl;
  cell_ctrl_t            cell_ctrl;
  logic [IDX_W-1:0]      rd_idx;
  logic [WORD_WIDTH-1:0] rd_word;
  logic [CMP_W-1:0]      pos_ext;
  logic [CMP_W-1:0]      cnt_ext;

  assign request.ready = !out_valid || result.ready;
  assign in_fire       = request.valid && request.ready;

  assign pos_ext = CMP_W'(request.position);
  assign cnt_ext = CMP_W'(count);

  always_comb begin
    res_status   = ST_OK;
    take         = 1'b0;
    op_ctrl.kind = CELL_HOLD;
    op_ctrl.at   = '0;
    rd_idx       = '0;
    count_next   = count;
    unique case (request.opcode)
      OP_PUSH_FRONT: begin
        if (count == COUNT_W'(CAPACITY)) begin
          res_status = ST_FULL;
        end else begin
          op_ctrl.kind = CELL_SHIFT_IN;
          count_next   = count + 1'b1;
        end
      end
      OP_PUSH_BACK: begin
        if (count == COUNT_W'(CAPACITY)) begin
          res_status = ST_FULL;
        end else begin
          op_ctrl.kind = CELL_LOAD;
          op_ctrl.at   = IDX_W'(count);
          count_next   = count + 1'b1;
        end
      end
      OP_POP_FRONT: begin
        if (count == '0) begin
          res_status = ST_EMPTY;
        end else begin
          op_ctrl.kind = CELL_REMOVE;
          take         = 1'b1;
          count_next   = count - 1'b1;
        end
      end
      OP_POP_BACK: begin
        if (count == '0) begin
          res_status = ST_EMPTY;
        end else begin
          op_ctrl.kind = CELL_REMOVE;
          op_ctrl.at   = IDX_W'(count - 1'b1);
          rd_idx       = IDX_W'(count - 1'b1);
          take         = 1'b1;
          count_next   = count - 1'b1;
        end
      end
      OP_REMOVE_AT: begin
        if (pos_ext >= cnt_ext) begin
          res_status = ST_RANGE;
        end else begin
          op_ctrl.kind = CELL_REMOVE;
          op_ctrl.at   = IDX_W'(pos_ext);
          rd_idx       = IDX_W'(pos_ext);
          take         = 1'b1;
          count_next   = count - 1'b1;
        end
      end
      default: begin
        res_status = ST_OK;
      end
    endcase
  end

  always_comb begin
    cell_ctrl = op_ctrl;
    if (!in_fire) begin
      cell_ctrl.kind = CELL_HOLD;
    end
  end

  dqir_chain u_chain (
    .clk       (clk),
    .ctrl      (cell_ctrl),
    .fill_word (WORD_WIDTH'(request.push_word)),
    .rd_idx    (rd_idx),
    .rd_word   (rd_word)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (in_fire) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_word   <= take ? OUT_W'(rd_word) : '0;
      out_status <= res_status;
      out_count  <= ENTRY_W'(count_next);
    end
  end

  assign result.valid       = out_valid;
  assign result.popped_word = out_word;
  assign result.status      = out_status;
  assign result.entry_count = out_count;

  `DQIR_ASSERT(a_count_bound, count <= COUNT_W'(CAPACITY), "entry count above capacity")
  `DQIR_ASSERT(a_error_keeps_count, in_fire && (res_status != ST_OK) |=> count == $past(count), "failed operation changed the count")
  `DQIR_ASSERT(a_empty_means_zero, out_valid && (out_status == ST_EMPTY) |-> count == '0, "empty status with entries held")
  `DQIR_ASSERT(a_beat_follows, in_fire |=> out_valid, "accepted request produced no result")
  `DQIR_ASSERT_ALWAYS(a_reset_clears, rst |=> !out_valid && (count == '0), "reset left a result or entries")

endmodule

>>> dv/deque_with_indexed_removal_tb.sv
// ----------------------------------------------------------------------------
// Deque with indexed removal testbench
// Drives push, pop and remove-at operations through the request channel and
// checks every result beat against a queue-based model of the deque. A short
// directed run covers the empty, full and out-of-range cases, then random
// fill, drain and mixed sequences run with random idling on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module deque_with_indexed_removal_tb;
  import dqir_pkg::*;

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [IN_W-1:0]     push_word;
    logic [POS_W-1:0]    position;
  } deque_request_t;

  typedef struct packed {
    logic [OUT_W-1:0]   popped_word;
    status_t            status;
    logic [ENTRY_W-1:0] entry_count;
  } deque_result_t;

  typedef enum int {
    MODE_FILL,
    MODE_DRAIN,
    MODE_MIXED
  } traffic_mode_t;

  localparam int HOLD_OFF_CYCLES = 80;
  localparam int HOLD_OFF_AFTER  = 700;
  localparam int QUIET_TAIL      = 150;
  localparam int WATCHDOG_LIMIT  = 2000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  dqir_in_if  req_if ();
  dqir_out_if res_if ();

  deque_with_indexed_removal i_dut (
    .clk     (clk),
    .rst     (rst),
    .request (req_if),
    .result  (res_if)
  );

  deque_request_t    pending_requests[$];
  deque_result_t     expected_results[$];
  logic [IN_W-1:0]   held_words[$];
  int                errors = 0;
  int                requests_sent = 0;
  int                requests_taken = 0;
  int                gen_count = 0;
  bit                quiet = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic deque_result_t apply_request(logic [OPCODE_W-1:0] op,
                                                  logic [IN_W-1:0] word,
                                                  logic [POS_W-1:0] pos);
    deque_result_t r;
    r.popped_word = '0;
    r.status = ST_OK;
    case (op)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (held_words.size() >= CAPACITY) begin
          r.status = ST_FULL;
        end else if (op == OP_PUSH_FRONT) begin
          held_words.push_front(word);
        end else begin
          held_words.push_back(word);
        end
      end
      OP_POP_FRONT: begin
        if (held_words.size() == 0) r.status = ST_EMPTY;
        else r.popped_word = held_words.pop_front();
      end
      OP_POP_BACK: begin
        if (held_words.size() == 0) r.status = ST_EMPTY;
        else r.popped_word = held_words.pop_back();
      end
      OP_REMOVE_AT: begin
        if (pos >= held_words.size()) begin
          r.status = ST_RANGE;
        end else begin
          r.popped_word = held_words[pos];
          held_words.delete(pos);
        end
      end
      default: ;
    endcase
    r.entry_count = ENTRY_W'(held_words.size());
    return r;
  endfunction

  // The generator tracks the entry count so that positions can be aimed
  // inside the occupied range.
  task automatic queue_request(logic [OPCODE_W-1:0] op, logic [IN_W-1:0] word,
                               logic [POS_W-1:0] pos);
    deque_request_t req;
    req.opcode = op;
    req.push_word = word;
    req.position = pos;
    pending_requests.push_back(req);
    case (op)
      OP_PUSH_FRONT, OP_PUSH_BACK: if (gen_count < CAPACITY) gen_count++;
      OP_POP_FRONT, OP_POP_BACK: if (gen_count > 0) gen_count--;
      OP_REMOVE_AT: if (pos < gen_count) gen_count--;
      default: ;
    endcase
  endtask

  function automatic logic [IN_W-1:0] random_word();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return $urandom();
  endfunction

  initial begin
    traffic_mode_t    mode;
    int               n;
    int               len;
    int               roll;
    logic [OPCODE_W-1:0] op;
    logic [POS_W-1:0] pos;

    req_if.valid = 1'b0;
    req_if.opcode = '0;
    req_if.push_word = '0;
    req_if.position = '0;
    res_if.ready = 1'b0;

    queue_request(OP_POP_FRONT, 32'h1234_5678, 4'd0);
    queue_request(OP_POP_BACK, 32'h0, 4'd15);
    queue_request(OP_REMOVE_AT, 32'h0, 4'd15);
    queue_request(OP_PUSH_BACK, 32'h0000_0000, 4'd0);
    queue_request(OP_PUSH_FRONT, 32'hFFFF_FFFF, 4'd0);
    queue_request(OP_REMOVE_AT, 32'h0, 4'd1);
    queue_request(3'd7, 32'hFFFF_FFFF, 4'd15);
    for (int i = 0; i < CAPACITY - 1; i++) begin
      queue_request((i % 2 == 0) ? OP_PUSH_BACK : OP_PUSH_FRONT,
                    (i % 2 == 0) ? 32'hA5A5_A5A5 ^ i : 32'h5A5A_5A5A ^ i, 4'd0);
    end
    queue_request(OP_PUSH_FRONT, 32'hDEAD_0001, 4'd0);
    queue_request(OP_PUSH_BACK, 32'hDEAD_0002, 4'd0);
    queue_request(OP_REMOVE_AT, 32'h0, 4'd15);
    queue_request(OP_REMOVE_AT, 32'h0, 4'd15);
    queue_request(3'd5, 32'h0, 4'd0);
    queue_request(3'd6, 32'h0, 4'd0);

    n = 0;
    while (n < 2000) begin
      mode = traffic_mode_t'($urandom_range(0, 2));
      len = $urandom_range(10, 50);
      repeat (len) begin
        roll = $urandom_range(0, 99);
        pos = POS_W'($urandom_range(0, 15));
        if (roll < 3) begin
          op = OPCODE_W'($urandom_range(5, 7));
        end else begin
          roll = $urandom_range(0, 99);
          if ((mode == MODE_FILL && roll < 75) || (mode == MODE_DRAIN && roll < 25) ||
              (mode == MODE_MIXED && roll < 50)) begin
            op = $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
          end else begin
            case ($urandom_range(0, 2))
              0: op = OP_POP_FRONT;
              1: op = OP_POP_BACK;
              default: op = OP_REMOVE_AT;
            endcase
            if (op == OP_REMOVE_AT) begin
              roll = $urandom_range(0, 9);
              if (gen_count > 0 && roll < 8) begin
                pos = POS_W'($urandom_range(0, gen_count - 1));
              end else if (roll == 8 && gen_count < CAPACITY) begin
                pos = POS_W'(gen_count);
              end
            end
          end
          n++;
        end
        queue_request(op, random_word(), pos);
      end
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    while (pending_requests.size() != 0 || req_if.valid) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (errors == 0) begin
      $display("deque_with_indexed_removal_tb: clean");
    end else begin
      $display("deque_with_indexed_removal_tb: errors");
    end
    $finish;
  end

  always @(posedge clk) begin
    int send_gap;
    deque_request_t req;
    if (rst) begin
      send_gap = 0;
      req_if.valid <= 1'b0;
    end else begin
      quiet = (pending_requests.size() < QUIET_TAIL) || ((requests_sent / 100) % 4 == 3);
      if (!req_if.valid || req_if.ready) begin
        if (send_gap != 0) begin
          send_gap--;
          req_if.valid <= 1'b0;
        end else if (pending_requests.size() != 0) begin
          req = pending_requests.pop_front();
          req_if.opcode <= req.opcode;
          req_if.push_word <= req.push_word;
          req_if.position <= req.position;
          req_if.valid <= 1'b1;
          requests_sent++;
          if (!quiet && $urandom_range(0, 3) == 0) send_gap = $urandom_range(1, 5);
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    int stall_left;
    int hold_left;
    bit hold_done;
    if (rst) begin
      stall_left = 0;
      hold_left = 0;
      hold_done = 1'b0;
      res_if.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      res_if.ready <= 1'b0;
    end else if (!hold_done && requests_taken >= HOLD_OFF_AFTER) begin
      hold_done = 1'b1;
      hold_left = HOLD_OFF_CYCLES - 1;
      res_if.ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      res_if.ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 3) == 0) begin
      stall_left = $urandom_range(1, 5) - 1;
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    deque_result_t want;
    if (!rst) begin
      if (res_if.valid && res_if.ready) begin
        if (expected_results.size() == 0) begin
          $error("result beat with no request outstanding");
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (res_if.popped_word !== want.popped_word) begin
            $error("popped_word: expected %h, actual %h", want.popped_word, res_if.popped_word);
            errors++;
          end
          if (res_if.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, res_if.status);
            errors++;
          end
          if (res_if.entry_count !== want.entry_count) begin
            $error("entry_count: expected %0d, actual %0d", want.entry_count,
                   res_if.entry_count);
            errors++;
          end
        end
      end
      if (req_if.valid && req_if.ready) begin
        expected_results.push_back(apply_request(req_if.opcode, req_if.push_word,
                                                 req_if.position));
        requests_taken++;
      end
    end
  end

  always @(posedge clk) begin
    int idle_cycles;
    if (rst || (req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("deque_with_indexed_removal_tb: errors");
        $finish;
      end
    end
  end

endmodule
